FILE: hw/rtl/lps_pkg.sv
// Shared codes and control types for the line pixel stepper.
package lps_pkg;

	// Command codes carried in the mode field of an input word.
	localparam logic MODE_START = 1'b0;
	localparam logic MODE_STEP  = 1'b1;

	// Status of the input stage as seen by the stepper core.
	typedef struct packed {
		logic valid;
		logic start;
	} lps_stage_t;

endpackage

FILE: hw/rtl/lps_cmd_if.sv
// Command channel: a start word with two endpoints, or a step word.
interface lps_cmd_if #(
	parameter int COORD_BITS = 12
);
	logic                  valid;
	logic                  ready;
	logic                  mode;
	logic [COORD_BITS-1:0] x_start;
	logic [COORD_BITS-1:0] y_start;
	logic [COORD_BITS-1:0] x_end;
	logic [COORD_BITS-1:0] y_end;

	modport source (output valid, mode, x_start, y_start, x_end, y_end, input ready);
	modport sink   (input valid, mode, x_start, y_start, x_end, y_end, output ready);
endinterface

FILE: hw/rtl/lps_pix_if.sv
// Pixel channel: one plotted pixel per word.
interface lps_pix_if #(
	parameter int COORD_BITS = 12
);
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] pixel_x;
	logic [COORD_BITS-1:0] pixel_y;
	logic                  last_pixel;

	modport source (output valid, pixel_x, pixel_y, last_pixel, input ready);
	modport sink   (input valid, pixel_x, pixel_y, last_pixel, output ready);
endinterface

FILE: hw/rtl/lps_setup.sv
// Line setup: orders the endpoints by x, finds the deltas, the major axis
// and the starting decision value.
module lps_setup #(
	parameter int COORD_BITS = 12
) (
	input  logic [COORD_BITS-1:0]        x_start,
	input  logic [COORD_BITS-1:0]        y_start,
	input  logic [COORD_BITS-1:0]        x_end,
	input  logic [COORD_BITS-1:0]        y_end,
	output logic [COORD_BITS-1:0]        org_x,
	output logic [COORD_BITS-1:0]        org_y,
	output logic                         steep,
	output logic                         y_neg,
	output logic [COORD_BITS-1:0]        major,
	output logic [COORD_BITS:0]          twice_major,
	output logic [COORD_BITS:0]          twice_minor,
	output logic signed [COORD_BITS+2:0] err_init
);
	logic                  swap;
	logic [COORD_BITS-1:0] xb;
	logic [COORD_BITS-1:0] yb;
	logic [COORD_BITS-1:0] dx;
	logic [COORD_BITS-1:0] dy;
	logic [COORD_BITS-1:0] minor;

	// Put the endpoint with the smaller x first.
	always_comb begin
		swap  = x_start > x_end;
		org_x = swap ? x_end : x_start;
		org_y = swap ? y_end : y_start;
		xb    = swap ? x_start : x_end;
		yb    = swap ? y_start : y_end;
	end

	// Absolute deltas and the choice of major axis.
	always_comb begin
		dx          = xb - org_x;
		y_neg       = org_y > yb;
		dy          = y_neg ? (org_y - yb) : (yb - org_y);
		steep       = dy > dx;
		major       = steep ? dy : dx;
		minor       = steep ? dx : dy;
		twice_major = {major, 1'b0};
		twice_minor = {minor, 1'b0};
		err_init    = $signed({2'b00, twice_minor}) - $signed({3'b000, major});
	end
endmodule

FILE: hw/rtl/lps_stepper.sv
// Stepper core: holds line state, gives one pixel per word of a line and
// advances the decision value, with a result register on the pixel side.
module lps_stepper #(
	parameter int COORD_BITS = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lps_pkg::lps_stage_t          stage,
	input  logic [COORD_BITS-1:0]        org_x,
	input  logic [COORD_BITS-1:0]        org_y,
	input  logic                         steep,
	input  logic                         y_neg,
	input  logic [COORD_BITS-1:0]        major,
	input  logic [COORD_BITS:0]          twice_major,
	input  logic [COORD_BITS:0]          twice_minor,
	input  logic signed [COORD_BITS+2:0] err_init,
	output logic                         take,
	lps_pix_if.source                    pix
);
	logic                         active_q;
	logic                         steep_q;
	logic                         yneg_q;
	logic [COORD_BITS-1:0]        cur_x_q;
	logic [COORD_BITS-1:0]        cur_y_q;
	logic signed [COORD_BITS+2:0] err_q;
	logic [COORD_BITS-1:0]        left_q;
	logic [COORD_BITS:0]          tmaj_q;
	logic [COORD_BITS:0]          tmin_q;

	logic                         e_steep;
	logic                         e_yneg;
	logic [COORD_BITS-1:0]        e_x;
	logic [COORD_BITS-1:0]        e_y;
	logic signed [COORD_BITS+2:0] e_err;
	logic [COORD_BITS-1:0]        e_left;
	logic [COORD_BITS:0]          e_tmaj;
	logic [COORD_BITS:0]          e_tmin;
	logic                         emits;
	logic                         last;
	logic                         err_pos;
	logic [COORD_BITS-1:0]        y_moved;
	logic [COORD_BITS-1:0]        n_x;
	logic [COORD_BITS-1:0]        n_y;
	logic signed [COORD_BITS+2:0] n_err;

	// A start word takes its values from setup, a step word from the state.
	always_comb begin
		if (stage.start) begin
			e_steep = steep;
			e_yneg  = y_neg;
			e_x     = org_x;
			e_y     = org_y;
			e_err   = err_init;
			e_left  = major;
			e_tmaj  = twice_major;
			e_tmin  = twice_minor;
		end else begin
			e_steep = steep_q;
			e_yneg  = yneg_q;
			e_x     = cur_x_q;
			e_y     = cur_y_q;
			e_err   = err_q;
			e_left  = left_q;
			e_tmaj  = tmaj_q;
			e_tmin  = tmin_q;
		end
	end

	// A word is consumed once the result register can take its pixel, if any.
	always_comb begin
		emits = stage.start || active_q;
		take  = stage.valid && (!emits || !pix.valid || pix.ready);
		last  = (e_left == '0);
	end

	// Next pixel: the major axis always moves, the minor one when the
	// decision value is positive.
	always_comb begin
		err_pos = (e_err > 0);
		y_moved = e_yneg ? (e_y - 1'b1) : (e_y + 1'b1);
		if (e_steep) begin
			n_y = y_moved;
			n_x = err_pos ? (e_x + 1'b1) : e_x;
		end else begin
			n_x = e_x + 1'b1;
			n_y = err_pos ? y_moved : e_y;
		end
		n_err = e_err + $signed({2'b00, e_tmin})
			- (err_pos ? $signed({2'b00, e_tmaj}) : $signed({(COORD_BITS+3){1'b0}}));
	end

	// Line state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			steep_q  <= 1'b0;
			yneg_q   <= 1'b0;
			cur_x_q  <= '0;
			cur_y_q  <= '0;
			err_q    <= '0;
			left_q   <= '0;
			tmaj_q   <= '0;
			tmin_q   <= '0;
		end else if (take && emits) begin
			steep_q <= e_steep;
			yneg_q  <= e_yneg;
			tmaj_q  <= e_tmaj;
			tmin_q  <= e_tmin;
			if (last) begin
				active_q <= 1'b0;
				cur_x_q  <= e_x;
				cur_y_q  <= e_y;
				err_q    <= e_err;
				left_q   <= e_left;
			end else begin
				active_q <= 1'b1;
				cur_x_q  <= n_x;
				cur_y_q  <= n_y;
				err_q    <= n_err;
				left_q   <= e_left - 1'b1;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix.valid <= 1'b0;
		end else if (take && emits) begin
			pix.valid <= 1'b1;
		end else if (pix.ready) begin
			pix.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && emits) begin
			pix.pixel_x    <= e_x;
			pix.pixel_y    <= e_y;
			pix.last_pixel <= last;
		end
	end
endmodule

FILE: hw/rtl/line_pixel_stepper.sv
// Channel  Direction  Word contents
// cmd      in         mode, x_start, y_start, x_end, y_end
// pix      out        pixel_x, pixel_y, last_pixel
//
// One pixel per clock while pix is not stalled: a word is registered
// after line setup, then the stepper core gives its pixel into the
// result register, so each pixel passes both registers on its way to pix.
// The rate is set by the decision update in the stepper core.
// Reset (arst_n low) drops any line in progress and empties both registers.
// A stall on pix holds the input stage; a step word with no line gives no pixel.
module line_pixel_stepper #(
	parameter int COORD_BITS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	lps_cmd_if.sink     cmd,
	lps_pix_if.source   pix
);
	logic [COORD_BITS-1:0]        su_org_x;
	logic [COORD_BITS-1:0]        su_org_y;
	logic                         su_steep;
	logic                         su_y_neg;
	logic [COORD_BITS-1:0]        su_major;
	logic [COORD_BITS:0]          su_tmaj;
	logic [COORD_BITS:0]          su_tmin;
	logic signed [COORD_BITS+2:0] su_err;

	logic                         valid_s1;
	logic                         start_s1;
	logic [COORD_BITS-1:0]        org_x_s1;
	logic [COORD_BITS-1:0]        org_y_s1;
	logic                         steep_s1;
	logic                         y_neg_s1;
	logic [COORD_BITS-1:0]        major_s1;
	logic [COORD_BITS:0]          tmaj_s1;
	logic [COORD_BITS:0]          tmin_s1;
	logic signed [COORD_BITS+2:0] err_s1;

	lps_pkg::lps_stage_t          stage;
	logic                         take;
	logic                         load;

	lps_setup #(.COORD_BITS(COORD_BITS)) u_setup (
		.x_start     (cmd.x_start),
		.y_start     (cmd.y_start),
		.x_end       (cmd.x_end),
		.y_end       (cmd.y_end),
		.org_x       (su_org_x),
		.org_y       (su_org_y),
		.steep       (su_steep),
		.y_neg       (su_y_neg),
		.major       (su_major),
		.twice_major (su_tmaj),
		.twice_minor (su_tmin),
		.err_init    (su_err)
	);

	// The input stage takes a word whenever it is empty or being drained.
	assign cmd.ready = !valid_s1 || take;
	assign load      = cmd.valid && cmd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			start_s1 <= (cmd.mode == lps_pkg::MODE_START);
			org_x_s1 <= su_org_x;
			org_y_s1 <= su_org_y;
			steep_s1 <= su_steep;
			y_neg_s1 <= su_y_neg;
			major_s1 <= su_major;
			tmaj_s1  <= su_tmaj;
			tmin_s1  <= su_tmin;
			err_s1   <= su_err;
		end
	end

	assign stage.valid = valid_s1;
	assign stage.start = start_s1;

	lps_stepper #(.COORD_BITS(COORD_BITS)) u_stepper (
		.clk         (clk),
		.arst_n      (arst_n),
		.stage       (stage),
		.org_x       (org_x_s1),
		.org_y       (org_y_s1),
		.steep       (steep_s1),
		.y_neg       (y_neg_s1),
		.major       (major_s1),
		.twice_major (tmaj_s1),
		.twice_minor (tmin_s1),
		.err_init    (err_s1),
		.take        (take),
		.pix         (pix)
	);
endmodule
